FILE: src/illl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types, codes and node store request bundle for the linked list engine
package illl_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 16;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int CMD_W       = 3;
  localparam int POS_W       = 11;
  localparam int STAT_W      = 2;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [SLOT_W:0]        link_t;   // one extra bit holds the empty-chain marker
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam logic [CMD_W-1:0] CMD_READ       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  // one write and one read port on each of the two node memories
  typedef struct packed {
    logic   link_we;
    slot_t  link_waddr;
    link_t  link_wdata;
    slot_t  link_raddr;
    logic   val_we;
    slot_t  val_waddr;
    value_t val_wdata;
    slot_t  val_raddr;
  } nstore_req_t;

endpackage
`default_nettype wire

FILE: src/illl_node_store.sv
`timescale 1ns / 1ps
`default_nettype none
// node link and value memories, registered read
module illl_node_store
  import illl_pkg::*;
(
  input  logic        clk,
  input  nstore_req_t req,
  output link_t       link_q,
  output value_t      val_q
);

  link_t  link_mem [CAPACITY];
  value_t val_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    link_q <= link_mem[req.link_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      val_mem[req.val_waddr] <= req.val_wdata;
    end
    val_q <= val_mem[req.val_raddr];
  end

endmodule
`default_nettype wire

FILE: src/indexed_linked_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// linked list engine top level: command sequencer, list registers and output stage
// steps from word taken to result word: bad position, unused command or full store go to finish;
//   head and tail inserts take a slot (tail then links the old tail), delete of the only node and
//   at head free the slot, reads, middle inserts and other deletes walk from head first
// one command in work at a time, next word taken the cycle after the result is loaded;
//   the walk follows one link per cycle, up to 1023 links
// reset clears head, tail, length, fresh slot count, free chain and output valid; node memories
//   are not cleared, entries are defined once written
module indexed_linked_list_engine_unit
  import illl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // command[2:0], position[13:3], value[29:14], zero pad
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // read_value[15:0], status[17:16], list_length[28:18], pad
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC,          // take a slot, write its value (and link for head/tail)
    ST_TAIL_LINK,      // hook new slot behind the old tail
    ST_WSTART,         // start the walk from head
    ST_WALK,           // one link per cycle
    ST_TARGET,         // walk done, cur holds the slot found
    ST_READ_OUT,
    ST_MID_LINK_NEW,   // new.link = before.link
    ST_MID_LINK_PREV,  // before.link = new
    ST_DEL_NEXT,       // victim = before.link
    ST_DEL_SKIP,       // before.link = victim.link
    ST_DEL_HEAD,       // head = head.link
    ST_DEL_FREE,       // push victim onto free chain
    ST_FINISH          // hand result to the output register
  } state_t;

  typedef enum logic [2:0] {
    OP_READ,
    OP_INS_HEAD,
    OP_INS_TAIL,
    OP_INS_MID,
    OP_DEL_MID
  } op_t;

  // input word fields
  logic [CMD_W-1:0] s_cmd;
  pos_t             s_pos;
  value_t           s_value;

  assign s_cmd   = s_tdata[2:0];
  assign s_pos   = s_tdata[13:3];
  assign s_value = s_tdata[29:14];

  // sequencer state
  state_t state;
  op_t    op;
  slot_t  cur;          // walk cursor, ends on the target or the node before it
  cnt_t   rem;          // links still to follow
  slot_t  new_slot;
  slot_t  del_slot;
  logic   at_tail;      // delete hits the last node
  value_t val_r;
  value_t res_value;
  logic [STAT_W-1:0] res_status;

  // list registers
  slot_t head;
  slot_t tail;
  cnt_t  count;
  cnt_t  fresh_used;
  link_t freed_head;    // CAPACITY marks an empty free chain

  // output register
  value_t            out_read_value;
  logic [STAT_W-1:0] out_status;
  cnt_t              out_length;

  // node store
  nstore_req_t req;
  link_t       link_q;
  value_t      val_q;

  illl_node_store u_store (
    .clk    (clk),
    .req    (req),
    .link_q (link_q),
    .val_q  (val_q)
  );

  // slot allocation: free chain first, then fresh slots in order
  logic  alloc_from_chain;
  slot_t alloc_slot;
  link_t chain_next;
  logic  full;

  always_comb begin
    alloc_from_chain = (freed_head < link_t'(CAPACITY));
    alloc_slot       = alloc_from_chain ? freed_head[SLOT_W-1:0] : fresh_used[SLOT_W-1:0];
    chain_next       = (link_q > link_t'(CAPACITY)) ? link_t'(CAPACITY) : link_q;
    full             = (count == cnt_t'(CAPACITY));
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {3'b000, out_length, out_status, out_read_value};

  // memory port steering per state
  always_comb begin
    req = '0;
    unique case (state)
      ST_IDLE: begin
        // head link for delete at front, else next free-chain entry for alloc
        req.link_raddr = (s_cmd == CMD_DELETE) ? head : freed_head[SLOT_W-1:0];
      end
      ST_ALLOC: begin
        req.val_we    = 1'b1;
        req.val_waddr = alloc_slot;
        req.val_wdata = val_r;
        if (op == OP_INS_HEAD) begin
          req.link_we    = 1'b1;
          req.link_waddr = alloc_slot;
          req.link_wdata = (count == '0) ? '0 : {1'b0, head};
        end else if (op == OP_INS_TAIL) begin
          req.link_we    = 1'b1;
          req.link_waddr = alloc_slot;
          req.link_wdata = '0;
        end
      end
      ST_TAIL_LINK: begin
        req.link_we    = 1'b1;
        req.link_waddr = tail;
        req.link_wdata = {1'b0, new_slot};
      end
      ST_WSTART: begin
        req.link_raddr = head;
      end
      ST_WALK: begin
        // chase the link that just came back
        req.link_raddr = link_q[SLOT_W-1:0];
      end
      ST_TARGET: begin
        req.link_raddr = cur;
        req.val_raddr  = cur;
      end
      ST_MID_LINK_NEW: begin
        req.link_we    = 1'b1;
        req.link_waddr = new_slot;
        req.link_wdata = {1'b0, link_q[SLOT_W-1:0]};
      end
      ST_MID_LINK_PREV: begin
        req.link_we    = 1'b1;
        req.link_waddr = cur;
        req.link_wdata = {1'b0, new_slot};
      end
      ST_DEL_NEXT: begin
        req.link_raddr = link_q[SLOT_W-1:0];
        if (at_tail) begin
          req.link_we    = 1'b1;
          req.link_waddr = cur;
          req.link_wdata = '0;
        end
      end
      ST_DEL_SKIP: begin
        req.link_we    = 1'b1;
        req.link_waddr = cur;
        req.link_wdata = {1'b0, link_q[SLOT_W-1:0]};
      end
      ST_DEL_FREE: begin
        req.link_we    = 1'b1;
        req.link_waddr = del_slot;
        req.link_wdata = freed_head;
      end
      ST_READ_OUT, ST_DEL_HEAD, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, list registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      fresh_used <= '0;
      freed_head <= link_t'(CAPACITY);
      m_tvalid   <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            val_r      <= s_value;
            res_value  <= '0;
            res_status <= STAT_OK;
            at_tail    <= (s_pos == cnt_t'(count - cnt_t'(1)));
            unique case (s_cmd)
              CMD_READ: begin
                if (s_pos < count) begin
                  op    <= OP_READ;
                  rem   <= s_pos;
                  state <= ST_WSTART;
                end else begin
                  res_status <= STAT_BAD_POS;
                  state      <= ST_FINISH;
                end
              end
              CMD_INS_HEAD, CMD_INS_TAIL: begin
                if (full) begin
                  res_status <= STAT_FULL;
                  state      <= ST_FINISH;
                end else begin
                  op    <= (s_cmd == CMD_INS_HEAD) ? OP_INS_HEAD : OP_INS_TAIL;
                  state <= ST_ALLOC;
                end
              end
              CMD_INS_BEFORE: begin
                // position check ranks above the full check
                if (s_pos > count) begin
                  res_status <= STAT_BAD_POS;
                  state      <= ST_FINISH;
                end else if (full) begin
                  res_status <= STAT_FULL;
                  state      <= ST_FINISH;
                end else begin
                  if (s_pos == '0) begin
                    op <= OP_INS_HEAD;
                  end else if (s_pos == count) begin
                    op <= OP_INS_TAIL;
                  end else begin
                    op <= OP_INS_MID;
                  end
                  rem   <= pos_t'(s_pos - pos_t'(1));
                  state <= ST_ALLOC;
                end
              end
              CMD_DELETE: begin
                if (s_pos >= count) begin
                  res_status <= STAT_BAD_POS;
                  state      <= ST_FINISH;
                end else if (count == cnt_t'(1)) begin
                  // last node goes, list empties
                  del_slot <= head;
                  head     <= '0;
                  tail     <= '0;
                  state    <= ST_DEL_FREE;
                end else if (s_pos == '0) begin
                  del_slot <= head;
                  state    <= ST_DEL_HEAD;
                end else begin
                  op    <= OP_DEL_MID;
                  rem   <= pos_t'(s_pos - pos_t'(1));
                  state <= ST_WSTART;
                end
              end
              default: begin
                res_status <= STAT_BAD_POS;
                state      <= ST_FINISH;
              end
            endcase
          end
        end
        ST_ALLOC: begin
          if (alloc_from_chain) begin
            freed_head <= chain_next;
          end else begin
            fresh_used <= fresh_used + cnt_t'(1);
          end
          unique case (op)
            OP_INS_HEAD: begin
              head <= alloc_slot;
              if (count == '0) begin
                tail <= alloc_slot;
              end
              count <= count + cnt_t'(1);
              state <= ST_FINISH;
            end
            OP_INS_TAIL: begin
              if (count == '0) begin
                head  <= alloc_slot;
                tail  <= alloc_slot;
                count <= count + cnt_t'(1);
                state <= ST_FINISH;
              end else begin
                new_slot <= alloc_slot;
                state    <= ST_TAIL_LINK;
              end
            end
            default: begin
              new_slot <= alloc_slot;
              state    <= ST_WSTART;
            end
          endcase
        end
        ST_TAIL_LINK: begin
          tail  <= new_slot;
          count <= count + cnt_t'(1);
          state <= ST_FINISH;
        end
        ST_WSTART: begin
          if (rem == '0) begin
            cur   <= head;
            state <= ST_TARGET;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          cur <= link_q[SLOT_W-1:0];
          rem <= rem - cnt_t'(1);
          if (rem == cnt_t'(1)) begin
            state <= ST_TARGET;
          end
        end
        ST_TARGET: begin
          unique case (op)
            OP_READ:    state <= ST_READ_OUT;
            OP_INS_MID: state <= ST_MID_LINK_NEW;
            default:    state <= ST_DEL_NEXT;
          endcase
        end
        ST_READ_OUT: begin
          res_value <= val_q;
          state     <= ST_FINISH;
        end
        ST_MID_LINK_NEW: begin
          state <= ST_MID_LINK_PREV;
        end
        ST_MID_LINK_PREV: begin
          count <= count + cnt_t'(1);
          state <= ST_FINISH;
        end
        ST_DEL_NEXT: begin
          del_slot <= link_q[SLOT_W-1:0];
          if (at_tail) begin
            tail  <= cur;
            state <= ST_DEL_FREE;
          end else begin
            state <= ST_DEL_SKIP;
          end
        end
        ST_DEL_SKIP: begin
          state <= ST_DEL_FREE;
        end
        ST_DEL_HEAD: begin
          head  <= link_q[SLOT_W-1:0];
          state <= ST_DEL_FREE;
        end
        ST_DEL_FREE: begin
          freed_head <= {1'b0, del_slot};
          count      <= count - cnt_t'(1);
          state      <= ST_FINISH;
        end
        ST_FINISH: begin
          // wait for the output register to be free
          if (!m_tvalid || m_tready) begin
            m_tvalid       <= 1'b1;
            out_read_value <= res_value;
            out_status     <= res_status;
            out_length     <= count;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // length never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(CAPACITY))
    else $error("list length above capacity");

  // every listed node came from a fresh slot at some point
  a_count_fresh: assert property (@(posedge clk) disable iff (rst)
    count <= fresh_used)
    else $error("list length above fresh slots handed out");

  // free chain head is a slot or the empty marker
  a_chain_bound: assert property (@(posedge clk) disable iff (rst)
    freed_head <= link_t'(CAPACITY))
    else $error("free chain head out of range");

  // a command changes the length by one at most
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |->
      (cnt_t'(count - $past(count)) == cnt_t'(1)) ||
      (cnt_t'($past(count) - count) == cnt_t'(1)))
    else $error("length jumped by more than one");

  // one command in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

  // results only come from the finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result word raised outside finish");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the linked list engine: list predictor, stream driver and checker
module tb_top
  import illl_pkg::*;
();

  localparam logic [CMD_W-1:0] CMD_LAST_CODE = 3'd7;
  localparam int               CALM_TAIL     = 150;  // last words run with no idling
  localparam int               SETTLE_CYCLES = 64;
  localparam int               LONG_LIST     = 160;  // length reached by the growth phase

  typedef struct packed {
    value_t           value;
    pos_t             pos;
    logic [CMD_W-1:0] cmd;
  } list_cmd_t;

  typedef struct packed {
    value_t            rd;
    logic [STAT_W-1:0] st;
    cnt_t              len;
  } list_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  indexed_linked_list_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  list_cmd_t    pend_q[$];
  list_result_t owed_results[$];
  int           err_count = 0;
  int           gen_len = 0;
  longint       cycle_count = 0;
  longint       cycle_limit = 0;
  int           cmd_tally[8];
  int           stat_tally[4];
  int           longest_list = 0;

  // ---------------------------------------------------------------------------
  // list predictor: node store, free chain and list registers
  // ---------------------------------------------------------------------------
  value_t      lst_val[CAPACITY];
  int unsigned lst_lnk[CAPACITY];
  int unsigned lst_head = 0;
  int unsigned lst_tail = 0;
  int unsigned lst_count = 0;
  int unsigned lst_fresh = 0;
  int unsigned lst_freed = CAPACITY;

  function automatic int unsigned slot_fit(int unsigned s);
    return (s < CAPACITY) ? s : 0;
  endfunction

  // slot holding list position n
  function automatic int unsigned slot_at(int unsigned n);
    int unsigned s;
    s = slot_fit(lst_head);
    repeat (n) s = slot_fit(lst_lnk[s]);
    return s;
  endfunction

  // freed slots first (most recent first), else the next never-used one
  function automatic int unsigned claim_slot(value_t v);
    int unsigned s;
    if (lst_freed < CAPACITY) begin
      s = lst_freed;
      lst_freed = lst_lnk[s];
      if (lst_freed > CAPACITY) lst_freed = CAPACITY;
    end else begin
      s = slot_fit(lst_fresh);
      if (lst_fresh < CAPACITY) lst_fresh++;
    end
    lst_val[s] = v;
    lst_lnk[s] = 0;
    return s;
  endfunction

  function automatic void link_at_head(value_t v);
    int unsigned s;
    s = claim_slot(v);
    if (lst_count == 0) lst_tail = s;
    else lst_lnk[s] = slot_fit(lst_head);
    lst_head = s;
    lst_count++;
  endfunction

  function automatic void link_at_tail(value_t v);
    int unsigned s;
    s = claim_slot(v);
    if (lst_count == 0) lst_head = s;
    else lst_lnk[slot_fit(lst_tail)] = s;
    lst_tail = s;
    lst_count++;
  endfunction

  function automatic void release_slot(int unsigned s);
    lst_lnk[s] = lst_freed;
    lst_freed = s;
  endfunction

  function automatic list_result_t list_apply(logic [CMD_W-1:0] cmd, int unsigned pos,
                                              value_t val);
    list_result_t r;
    int unsigned  prior;
    int unsigned  s;
    logic         full;
    r = '0;
    full = (lst_count >= CAPACITY);
    case (cmd)
      CMD_READ: begin
        if (pos < lst_count) r.rd = lst_val[slot_at(pos)];
        else r.st = STAT_BAD_POS;
      end
      CMD_INS_HEAD: begin
        if (full) r.st = STAT_FULL;
        else link_at_head(val);
      end
      CMD_INS_TAIL: begin
        if (full) r.st = STAT_FULL;
        else link_at_tail(val);
      end
      CMD_INS_BEFORE: begin
        // position check wins over the full check
        if (pos > lst_count) r.st = STAT_BAD_POS;
        else if (full) r.st = STAT_FULL;
        else if (pos == 0) link_at_head(val);
        else if (pos == lst_count) link_at_tail(val);
        else begin
          prior = slot_at(pos - 1);
          s = claim_slot(val);
          lst_lnk[s] = slot_fit(lst_lnk[prior]);
          lst_lnk[prior] = s;
          lst_count++;
        end
      end
      CMD_DELETE: begin
        if (pos >= lst_count) r.st = STAT_BAD_POS;
        else if (lst_count == 1) begin
          release_slot(slot_fit(lst_head));
          lst_head = 0;
          lst_tail = 0;
          lst_count = 0;
        end else if (pos == 0) begin
          s = slot_fit(lst_head);
          lst_head = slot_fit(lst_lnk[s]);
          release_slot(s);
          lst_count--;
        end else begin
          prior = slot_at(pos - 1);
          s = slot_fit(lst_lnk[prior]);
          if (pos == lst_count - 1) begin
            // tail goes, its predecessor takes over
            lst_lnk[prior] = 0;
            lst_tail = prior;
          end else begin
            lst_lnk[prior] = slot_fit(lst_lnk[s]);
          end
          release_slot(s);
          lst_count--;
        end
      end
      default: r.st = STAT_BAD_POS;
    endcase
    r.len = cnt_t'(lst_count);
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building; gen_len follows the list length as the words are queued
  // ---------------------------------------------------------------------------
  task automatic queue_command(logic [CMD_W-1:0] cmd, int unsigned pos, value_t val);
    list_cmd_t w;
    w.cmd   = cmd;
    w.pos   = pos_t'(pos);
    w.value = val;
    pend_q.push_back(w);
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL: if (gen_len < CAPACITY) gen_len++;
      CMD_INS_BEFORE: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
      CMD_DELETE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // mostly well-formed positions on a short list, some at the edges, some anywhere
  task automatic queue_random(int n, int len_cap);
    logic [CMD_W-1:0] c;
    int               r;
    int               q;
    int               span;
    int unsigned      p;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (gen_len > len_cap && r < 50) c = CMD_DELETE;
      else if (r < 25) c = CMD_READ;
      else if (r < 40) c = CMD_INS_HEAD;
      else if (r < 55) c = CMD_INS_TAIL;
      else if (r < 75) c = CMD_INS_BEFORE;
      else if (r < 95) c = CMD_DELETE;
      else c = CMD_W'($urandom_range(CMD_DELETE + 1, CMD_LAST_CODE));
      span = (c == CMD_INS_BEFORE) ? gen_len + 1 : gen_len;
      q = $urandom_range(0, 99);
      if (q < 80 && span > 0) p = $urandom_range(0, span - 1);
      else if (q < 90) p = gen_len + $urandom_range(0, 1);
      else p = $urandom_range(0, 2047);
      queue_command(c, p, value_t'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // command driver: takes words from pend_q, predicts on acceptance
  // ---------------------------------------------------------------------------
  int drv_gap = 0;
  int drv_pct = 10;
  int drv_taken = 0;

  always @(posedge clk) begin : cmd_drive
    list_cmd_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        w = list_cmd_t'(s_tdata[29:0]);
        cmd_tally[w.cmd]++;
        owed_results.push_back(list_apply(w.cmd, w.pos, w.value));
        drv_taken++;
        // idle density changes now and then, zero included
        if (drv_taken % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: drv_pct = 0;
            1: drv_pct = 8;
            2: drv_pct = 25;
            default: drv_pct = 50;
          endcase
        end
      end
      if (!s_tvalid || s_tready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          s_tvalid <= 1'b0;
        end else if (pend_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pend_q.size() > CALM_TAIL && $urandom_range(0, 99) < drv_pct) begin
          drv_gap = $urandom_range(0, 14);
          s_tvalid <= 1'b0;
        end else begin
          w = pend_q.pop_front();
          s_tdata  <= {2'b00, w};
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker with random back-pressure
  // ---------------------------------------------------------------------------
  int mon_gap = 0;
  int mon_pct = 10;
  int mon_seen = 0;

  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.rd  = m_tdata[15:0];
        got.st  = m_tdata[17:16];
        got.len = m_tdata[28:18];
        stat_tally[got.st]++;
        if (int'(got.len) > longest_list) longest_list = int'(got.len);
        if (owed_results.size() == 0) begin
          report_error($sformatf("result word %h with nothing outstanding", m_tdata));
        end else begin
          want = owed_results.pop_front();
          if (got.rd !== want.rd)
            report_error($sformatf("read_value %h, want %h", got.rd, want.rd));
          if (got.st !== want.st)
            report_error($sformatf("status %0d, want %0d", got.st, want.st));
          if (got.len !== want.len)
            report_error($sformatf("list_length %0d, want %0d", got.len, want.len));
        end
        mon_seen++;
        if (mon_seen % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: mon_pct = 0;
            1: mon_pct = 8;
            2: mon_pct = 25;
            default: mon_pct = 50;
          endcase
        end
      end
      if (mon_gap > 0) begin
        mon_gap--;
        m_tready <= 1'b0;
      end else if (pend_q.size() > CALM_TAIL && $urandom_range(0, 99) < mon_pct) begin
        mon_gap = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_limit > 0 && cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles, %0d words unsent, %0d results outstanding",
               cycle_count, pend_q.size(), owed_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int r;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    foreach (stat_tally[i]) stat_tally[i] = 0;

    // directed: empty list, bad positions, unused codes, head / tail / middle edits
    queue_command(CMD_READ, 0, 16'h0000);
    queue_command(CMD_DELETE, 0, 16'h0000);
    queue_command(CMD_INS_BEFORE, 1, 16'h1111);
    queue_command(CMD_INS_BEFORE, 2047, 16'hFFFF);
    for (int c = CMD_DELETE + 1; c <= CMD_LAST_CODE; c++)
      queue_command(CMD_W'(c), 2047, 16'hFFFF);
    queue_command(CMD_INS_TAIL, 0, 16'hFFFF);      // tail insert into empty list
    queue_command(CMD_DELETE, 0, 16'h0000);        // removes the only node
    queue_command(CMD_INS_BEFORE, 0, 16'h0001);    // position zero goes to the head
    queue_command(CMD_INS_HEAD, 0, 16'h0000);
    queue_command(CMD_INS_BEFORE, 2, 16'h8000);    // position equal to length goes to tail
    queue_command(CMD_INS_BEFORE, 1, 16'h5A5A);
    queue_command(CMD_INS_TAIL, 0, 16'hA5A5);
    queue_command(CMD_READ, 0, 16'h0000);
    queue_command(CMD_READ, 4, 16'h0000);
    queue_command(CMD_READ, 5, 16'h0000);
    queue_command(CMD_READ, 2047, 16'h0000);
    queue_command(CMD_DELETE, 2, 16'h0000);
    queue_command(CMD_DELETE, 3, 16'h0000);        // tail delete
    queue_command(CMD_DELETE, 0, 16'h0000);        // head delete
    queue_command(CMD_READ, 1, 16'h0000);
    queue_command(CMD_DELETE, 5, 16'h0000);
    queue_command(CMD_INS_HEAD, 0, 16'h1234);

    queue_random(200, 48);

    // grow a long list for deep walks, reusing the free chain along the way
    while (gen_len < LONG_LIST) begin
      r = $urandom_range(0, 99);
      if (r < 40) queue_command(CMD_INS_HEAD, 0, value_t'($urandom()));
      else if (r < 80) queue_command(CMD_INS_TAIL, 0, value_t'($urandom()));
      else queue_command(CMD_INS_BEFORE, $urandom_range(0, gen_len), value_t'($urandom()));
    end

    // far end of the long list and positions past it
    queue_command(CMD_READ, gen_len - 1, 16'h0000);
    queue_command(CMD_READ, gen_len, 16'h0000);
    queue_command(CMD_INS_BEFORE, gen_len + 1, 16'hBEEF);
    queue_command(CMD_READ, CAPACITY, 16'h0000);
    queue_command(CMD_INS_BEFORE, CAPACITY + 1, 16'hBEEF);
    queue_command(CMD_DELETE, gen_len - 1, 16'h0000);
    queue_command(CMD_DELETE, gen_len / 2, 16'h0000);
    queue_command(CMD_INS_BEFORE, gen_len / 2, value_t'($urandom()));
    queue_command(CMD_READ, gen_len / 2, 16'h0000);
    queue_command(CMD_INS_TAIL, 0, 16'hBEEF);
    queue_command(CMD_READ, gen_len - 1, 16'h0000);

    // scattered deletes leave a free chain for the last phase
    repeat (20) queue_command(CMD_DELETE, $urandom_range(0, gen_len - 1), 16'h0000);

    queue_random(180, 40);

    cycle_limit = longint'(pend_q.size()) * (CAPACITY + 48) * 4 + 10000;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() > 0 || s_tvalid || owed_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d reads, %0d head, %0d tail, %0d before inserts, %0d deletes, %0d unused",
             cmd_tally[CMD_READ], cmd_tally[CMD_INS_HEAD], cmd_tally[CMD_INS_TAIL],
             cmd_tally[CMD_INS_BEFORE], cmd_tally[CMD_DELETE],
             cmd_tally[5] + cmd_tally[6] + cmd_tally[7]);
    $display("results: %0d done, %0d bad position, %0d store full; longest list %0d",
             stat_tally[STAT_OK], stat_tally[STAT_BAD_POS], stat_tally[STAT_FULL],
             longest_list);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: indexed_linked_list_engine_unit.f
src/illl_pkg.sv
src/illl_node_store.sv
src/indexed_linked_list_engine_unit.sv
test/tb_top.sv
